>>> rtl/msp_pkg.sv
// msp_pkg: shared types, codes and the CRC-8 step for the MSP frame decoder.
// Used by every module of the decoder and by its checker; no dependencies.
package msp_pkg;

  // parser state codes
  localparam logic [4:0] S_START      = 5'd0;
  localparam logic [4:0] S_MAGIC      = 5'd1;
  localparam logic [4:0] S_DIR        = 5'd2;
  localparam logic [4:0] S_V1_LEN     = 5'd3;
  localparam logic [4:0] S_V1_OPCODE  = 5'd4;
  localparam logic [4:0] S_V1_JL      = 5'd5;
  localparam logic [4:0] S_V1_JH      = 5'd6;
  localparam logic [4:0] S_V1_PAY     = 5'd7;
  localparam logic [4:0] S_V1_SUM     = 5'd8;
  localparam logic [4:0] S_V2_FLAGBYTE = 5'd9;
  localparam logic [4:0] S_V2_CL      = 5'd10;
  localparam logic [4:0] S_V2_CH      = 5'd11;
  localparam logic [4:0] S_V2_SL      = 5'd12;
  localparam logic [4:0] S_V2_SH      = 5'd13;
  localparam logic [4:0] S_V2_PAY     = 5'd14;
  localparam logic [4:0] S_V2_SUM     = 5'd15;
  localparam logic [4:0] S_VO_FLAGS   = 5'd16;
  localparam logic [4:0] S_VO_CL      = 5'd17;
  localparam logic [4:0] S_VO_CH      = 5'd18;
  localparam logic [4:0] S_VO_SL      = 5'd19;
  localparam logic [4:0] S_VO_SH      = 5'd20;
  localparam logic [4:0] S_VO_PAY     = 5'd21;
  localparam logic [4:0] S_VO_CRC     = 5'd22;
  localparam logic [4:0] S_VO_XOR     = 5'd23;

  // result status codes
  localparam logic [2:0] STAT_NEED    = 3'd0;
  localparam logic [2:0] STAT_PAYLOAD = 3'd1;
  localparam logic [2:0] STAT_DONE    = 3'd2;
  localparam logic [2:0] STAT_ERROR   = 3'd3;
  localparam logic [2:0] STAT_ABANDON = 3'd4;

  localparam logic [1:0] VER_V1   = 2'd0;
  localparam logic [1:0] VER_V2   = 2'd1;
  localparam logic [1:0] VER_V2O1 = 2'd2;

  localparam logic [1:0] DIR_REQ   = 2'd0;
  localparam logic [1:0] DIR_REPLY = 2'd1;
  localparam logic [1:0] DIR_ERR   = 2'd2;

  localparam logic [7:0] CH_START = 8'h24; // '$'
  localparam logic [7:0] CH_V1    = 8'h4D; // 'M'
  localparam logic [7:0] CH_V2    = 8'h58; // 'X'
  localparam logic [7:0] CH_REQ   = 8'h3C; // '<'
  localparam logic [7:0] CH_REPLY = 8'h3E; // '>'
  localparam logic [7:0] CH_ERR   = 8'h21; // '!'

  localparam logic [7:0] JUMBO_CODE   = 8'd255;
  localparam logic [7:0] V2_MIN_SIZE  = 8'd6;
  localparam logic [7:0] CRC_POLY     = 8'hD5;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] command;
    logic [1:0]  protocol_version;
    logic [1:0]  direction;
    logic [7:0]  frame_flags;
    logic [15:0] payload_size;
  } res_t;

  // one byte of CRC-8 DVB-S2, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

>>> rtl/msp_parser.sv
// msp_parser: frame parse state, header fields, running XOR and CRC-8.
// Computes the result for the byte in the input register; depends on msp_pkg.
module msp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              fire,
  input  logic [7:0]        rx,
  output msp_pkg::res_t     res
);

  logic [15:0] max_payload;
  logic [4:0]  parse_state, parse_state_next;
  logic [1:0]  version_code, version_code_next;
  logic [1:0]  direction_code, direction_code_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [15:0] command_reg, command_reg_next;
  logic [7:0]  v1_size_byte, v1_size_byte_next;
  logic [15:0] declared_size, declared_size_next;
  logic [15:0] payload_offset, payload_offset_next;
  logic [7:0]  xor_sum, xor_sum_next;
  logic [7:0]  crc_sum, crc_sum_next;

  logic        go_idle;
  logic [15:0] hi_size;
  logic [15:0] offset_inc;
  logic        pay_bad;
  logic [7:0]  crc_run;
  logic [7:0]  crc_first;

  assign hi_size    = declared_size | {rx, 8'h00};
  assign offset_inc = payload_offset + 16'd1;
  assign pay_bad    = (payload_offset >= declared_size) || (payload_offset >= max_payload);
  assign crc_run    = msp_pkg::crc8_step(crc_sum, rx);
  assign crc_first  = msp_pkg::crc8_step(8'h00, rx);

  always_comb begin
    parse_state_next    = parse_state;
    version_code_next   = version_code;
    direction_code_next = direction_code;
    flags_reg_next      = flags_reg;
    command_reg_next    = command_reg;
    v1_size_byte_next   = v1_size_byte;
    declared_size_next  = declared_size;
    payload_offset_next = payload_offset;
    xor_sum_next        = xor_sum;
    crc_sum_next        = crc_sum;
    go_idle             = 1'b0;
    res                 = '0;
    res.status          = msp_pkg::STAT_NEED;

    unique case (parse_state)
      msp_pkg::S_START: begin
        if (rx == msp_pkg::CH_START) parse_state_next = msp_pkg::S_MAGIC;
      end
      msp_pkg::S_MAGIC: begin
        if (rx == msp_pkg::CH_V1) begin
          version_code_next = msp_pkg::VER_V1;
          parse_state_next  = msp_pkg::S_DIR;
        end else if (rx == msp_pkg::CH_V2) begin
          version_code_next = msp_pkg::VER_V2;
          parse_state_next  = msp_pkg::S_DIR;
        end else begin
          go_idle = 1'b1;
        end
      end
      msp_pkg::S_DIR: begin
        if (rx == msp_pkg::CH_REQ || rx == msp_pkg::CH_REPLY || rx == msp_pkg::CH_ERR) begin
          if (rx == msp_pkg::CH_REQ)        direction_code_next = msp_pkg::DIR_REQ;
          else if (rx == msp_pkg::CH_REPLY) direction_code_next = msp_pkg::DIR_REPLY;
          else                              direction_code_next = msp_pkg::DIR_ERR;
          xor_sum_next        = 8'h00;
          crc_sum_next        = 8'h00;
          payload_offset_next = 16'd0;
          declared_size_next  = 16'd0;
          v1_size_byte_next   = 8'h00;
          flags_reg_next      = 8'h00;
          parse_state_next    = (version_code == msp_pkg::VER_V1) ? msp_pkg::S_V1_LEN
                                                                  : msp_pkg::S_V2_FLAGBYTE;
        end else begin
          go_idle = 1'b1;
        end
      end
      msp_pkg::S_V1_LEN: begin
        xor_sum_next      = xor_sum ^ rx;
        v1_size_byte_next = rx;
        parse_state_next  = msp_pkg::S_V1_OPCODE;
      end
      msp_pkg::S_V1_OPCODE: begin
        xor_sum_next     = xor_sum ^ rx;
        command_reg_next = {8'h00, rx};
        if (v1_size_byte == msp_pkg::JUMBO_CODE) begin
          parse_state_next = msp_pkg::S_V1_JL;
        end else if (rx == msp_pkg::JUMBO_CODE && v1_size_byte >= msp_pkg::V2_MIN_SIZE) begin
          version_code_next = msp_pkg::VER_V2O1;
          parse_state_next  = msp_pkg::S_VO_FLAGS;
        end else begin
          declared_size_next  = {8'h00, v1_size_byte};
          payload_offset_next = 16'd0;
          parse_state_next    = (v1_size_byte != 8'h00) ? msp_pkg::S_V1_PAY
                                                        : msp_pkg::S_V1_SUM;
        end
      end
      msp_pkg::S_V1_JL: begin
        xor_sum_next       = xor_sum ^ rx;
        declared_size_next = {8'h00, rx};
        parse_state_next   = msp_pkg::S_V1_JH;
      end
      msp_pkg::S_V1_JH: begin
        xor_sum_next       = xor_sum ^ rx;
        declared_size_next = hi_size;
        if (hi_size > max_payload) begin
          go_idle    = 1'b1;
          res.status = msp_pkg::STAT_ERROR;
        end else if (command_reg == {8'h00, msp_pkg::JUMBO_CODE}) begin
          version_code_next = msp_pkg::VER_V2O1;
          parse_state_next  = msp_pkg::S_VO_FLAGS;
        end else begin
          payload_offset_next = 16'd0;
          parse_state_next    = (hi_size != 16'd0) ? msp_pkg::S_V1_PAY : msp_pkg::S_V1_SUM;
        end
      end
      msp_pkg::S_V1_PAY, msp_pkg::S_V2_PAY, msp_pkg::S_VO_PAY: begin
        if (pay_bad) begin
          go_idle    = 1'b1;
          res.status = msp_pkg::STAT_ABANDON;
        end else begin
          res.status          = msp_pkg::STAT_PAYLOAD;
          res.data_byte       = rx;
          res.byte_index      = payload_offset;
          payload_offset_next = offset_inc;
          if (parse_state != msp_pkg::S_V2_PAY) xor_sum_next = xor_sum ^ rx;
          if (parse_state != msp_pkg::S_V1_PAY) crc_sum_next = crc_run;
          if (offset_inc == declared_size) begin
            if (parse_state == msp_pkg::S_V1_PAY)      parse_state_next = msp_pkg::S_V1_SUM;
            else if (parse_state == msp_pkg::S_V2_PAY) parse_state_next = msp_pkg::S_V2_SUM;
            else                                       parse_state_next = msp_pkg::S_VO_CRC;
          end
        end
      end
      msp_pkg::S_V1_SUM, msp_pkg::S_V2_SUM, msp_pkg::S_VO_XOR: begin
        go_idle = 1'b1;
        if ((parse_state == msp_pkg::S_V2_SUM) ? (crc_sum == rx) : (xor_sum == rx)) begin
          res.status           = msp_pkg::STAT_DONE;
          res.command          = command_reg;
          res.protocol_version = version_code;
          res.direction        = direction_code;
          res.frame_flags      = flags_reg;
          res.payload_size     = payload_offset;
        end else begin
          res.status = msp_pkg::STAT_ERROR;
        end
      end
      msp_pkg::S_V2_FLAGBYTE, msp_pkg::S_VO_FLAGS: begin
        flags_reg_next = rx;
        crc_sum_next   = crc_first;
        if (parse_state == msp_pkg::S_VO_FLAGS) begin
          xor_sum_next     = xor_sum ^ rx;
          parse_state_next = msp_pkg::S_VO_CL;
        end else begin
          parse_state_next = msp_pkg::S_V2_CL;
        end
      end
      msp_pkg::S_V2_CL, msp_pkg::S_VO_CL: begin
        command_reg_next = {8'h00, rx};
        crc_sum_next     = crc_run;
        if (parse_state == msp_pkg::S_VO_CL) begin
          xor_sum_next     = xor_sum ^ rx;
          parse_state_next = msp_pkg::S_VO_CH;
        end else begin
          parse_state_next = msp_pkg::S_V2_CH;
        end
      end
      msp_pkg::S_V2_CH, msp_pkg::S_VO_CH: begin
        command_reg_next = command_reg | {rx, 8'h00};
        crc_sum_next     = crc_run;
        if (parse_state == msp_pkg::S_VO_CH) begin
          xor_sum_next     = xor_sum ^ rx;
          parse_state_next = msp_pkg::S_VO_SL;
        end else begin
          parse_state_next = msp_pkg::S_V2_SL;
        end
      end
      msp_pkg::S_V2_SL, msp_pkg::S_VO_SL: begin
        declared_size_next = {8'h00, rx};
        crc_sum_next       = crc_run;
        if (parse_state == msp_pkg::S_VO_SL) begin
          xor_sum_next     = xor_sum ^ rx;
          parse_state_next = msp_pkg::S_VO_SH;
        end else begin
          parse_state_next = msp_pkg::S_V2_SH;
        end
      end
      msp_pkg::S_V2_SH, msp_pkg::S_VO_SH: begin
        declared_size_next = hi_size;
        crc_sum_next       = crc_run;
        if (parse_state == msp_pkg::S_VO_SH) xor_sum_next = xor_sum ^ rx;
        if (hi_size > max_payload) begin
          go_idle    = 1'b1;
          res.status = msp_pkg::STAT_ERROR;
        end else begin
          payload_offset_next = 16'd0;
          if (parse_state == msp_pkg::S_VO_SH)
            parse_state_next = (hi_size != 16'd0) ? msp_pkg::S_VO_PAY : msp_pkg::S_VO_CRC;
          else
            parse_state_next = (hi_size != 16'd0) ? msp_pkg::S_V2_PAY : msp_pkg::S_V2_SUM;
        end
      end
      msp_pkg::S_VO_CRC: begin
        xor_sum_next = xor_sum ^ rx;
        if (crc_sum == rx) begin
          parse_state_next = msp_pkg::S_VO_XOR;
        end else begin
          go_idle    = 1'b1;
          res.status = msp_pkg::STAT_ERROR;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      parse_state_next    = msp_pkg::S_START;
      payload_offset_next = 16'd0;
      xor_sum_next        = 8'h00;
      crc_sum_next        = 8'h00;
      declared_size_next  = 16'd0;
      v1_size_byte_next   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= msp_pkg::MAX_PAYLOAD_RST;
      parse_state    <= msp_pkg::S_START;
      version_code   <= msp_pkg::VER_V1;
      direction_code <= msp_pkg::DIR_REQ;
      flags_reg      <= 8'h00;
      command_reg    <= 16'd0;
      v1_size_byte   <= 8'h00;
      declared_size  <= 16'd0;
      payload_offset <= 16'd0;
      xor_sum        <= 8'h00;
      crc_sum        <= 8'h00;
    end else begin
      if (cfg_we) max_payload <= cfg_wdata;
      if (fire) begin
        parse_state    <= parse_state_next;
        version_code   <= version_code_next;
        direction_code <= direction_code_next;
        flags_reg      <= flags_reg_next;
        command_reg    <= command_reg_next;
        v1_size_byte   <= v1_size_byte_next;
        declared_size  <= declared_size_next;
        payload_offset <= payload_offset_next;
        xor_sum        <= xor_sum_next;
        crc_sum        <= crc_sum_next;
      end
    end
  end

endmodule

>>> rtl/msp_out_stage.sv
// msp_out_stage: result register with valid/stall handshake toward the consumer.
// Holds one res_t; depends on msp_pkg.
module msp_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  msp_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          can_load,
  output logic          out_valid,
  output msp_pkg::res_t res_q
);

  // the register is free when empty or being taken this cycle
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) res_q <= res_in;
  end

endmodule

>>> rtl/msp_frame_decoder.sv
// msp_frame_decoder: top level of the byte-serial MSP v1/v2 frame decoder.
// Instantiates msp_parser and msp_out_stage; depends on msp_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall / rx_byte, one received byte per request.
//   Output channel: out_valid / out_stall and the result fields, exactly one
//   result per byte. Payload bytes come out with status 1 and their index;
//   the consumer discards them if the frame ends with status 3 or 4.
//   Configuration: cfg_we / cfg_wdata write max_payload (reset 512); write it
//   only while no byte is in flight.
//   Path: an accepted byte is held in the input register and its result is
//   loaded into the result register when that register is free.
//   Throughput: one byte per cycle while out_stall is low. The whole parse
//   step (state decode, XOR, one CRC-8 byte step, size compares) sits between
//   the input register and the result register.
//   Reset: the parser waits for '$', all header fields and sums are zero,
//   both registers are empty.
//   Stall: while out_stall holds a waiting result, one more byte is taken into
//   the input register; after that in_stall rises until the result is taken.
module msp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_index,
  output logic [15:0] command,
  output logic [1:0]  protocol_version,
  output logic [1:0]  direction,
  output logic [7:0]  frame_flags,
  output logic [15:0] payload_size
);

  logic          in_full;
  logic [7:0]    in_byte;
  logic          can_load;
  logic          fire;
  logic          accept;
  msp_pkg::res_t res_c;
  msp_pkg::res_t res_q;

  assign fire     = in_full && can_load;
  assign in_stall = in_full && !can_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_byte <= rx_byte;
  end

  msp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .rx        (in_byte),
    .res       (res_c)
  );

  msp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_c),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign status           = res_q.status;
  assign data_byte        = res_q.data_byte;
  assign byte_index       = res_q.byte_index;
  assign command          = res_q.command;
  assign protocol_version = res_q.protocol_version;
  assign direction        = res_q.direction;
  assign frame_flags      = res_q.frame_flags;
  assign payload_size     = res_q.payload_size;

endmodule

>>> rtl/msp_checker.sv
// msp_checker: port-level assertions for msp_frame_decoder, bound to the top.
// Depends on msp_pkg and the top level's port list.
module msp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [7:0]  data_byte,
  input logic [15:0] byte_index,
  input logic [15:0] command,
  input logic [7:0]  frame_flags,
  input logic [15:0] payload_size
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_byte)
                               && $stable(byte_index))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != msp_pkg::STAT_PAYLOAD |-> data_byte == 8'h00 && byte_index == 16'd0)
    else $error("data or index set outside a payload byte");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != msp_pkg::STAT_DONE |-> command == 16'd0 && payload_size == 16'd0
                                                   && frame_flags == 8'h00)
    else $error("header fields set without frame done");

endmodule

bind msp_frame_decoder msp_checker u_msp_checker (.*);
